FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bbc_pkg.sv
// Package with the codes, types and decode functions of the bracket checker.
package bbc_pkg;

   localparam int STACK_DEPTH_DEF = 128;

   localparam int CHAR_W    = 8;
   localparam int DEPTH_W   = 8;
   localparam int VERDICT_W = 2;
   localparam int KIND_W    = 2;

   // Verdict codes; the error codes double as the sticky status values.
   localparam logic [VERDICT_W-1:0] VERDICT_PEND  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_BAL   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_UNBAL = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_OVER  = 2'd3;

   localparam logic [VERDICT_W-1:0] STATUS_NONE = 2'd0;

   // Bracket kind codes; zero means the character is no bracket of that side.
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic                 is_final;
      logic [DEPTH_W-1:0]   nesting_depth;
   } rsp_item_type;

   function automatic logic [KIND_W-1:0] open_kind(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         CHAR_OPEN_ROUND:  k = KIND_ROUND;
         CHAR_OPEN_SQUARE: k = KIND_SQUARE;
         CHAR_OPEN_CURLY:  k = KIND_CURLY;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] close_kind(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         CHAR_CLOSE_ROUND:  k = KIND_ROUND;
         CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
         CHAR_CLOSE_CURLY:  k = KIND_CURLY;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

FILE: hdl/bbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bbc_core.sv
// Stack controller: count, top-of-stack and sticky status around the stack RAM.
module bbc_core #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  logic [bbc_pkg::CHAR_W-1:0] char_in,
   input  logic                       last_char,
   output bbc_pkg::rsp_item_type      result
);

   import bbc_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]        count_ff, count_in, cnt_nx;
   logic [VERDICT_W-1:0] sticky_ff, sticky_in, st_nx;
   logic [KIND_W-1:0]    top_ff, top_in, top_nx;
   logic [KIND_W-1:0]    ok, ck, second;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;

   assign ok = open_kind(char_in);
   assign ck = close_kind(char_in);

   // The RAM read port always fetches the entry below the top for the next cycle.
   bbc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ok),
      .rd_addr (rd_addr),
      .rd_data (second)
   );

   always_comb begin
      cnt_nx = count_ff;
      st_nx  = sticky_ff;
      top_nx = top_ff;
      wr_en  = 1'b0;
      if (item_valid && sticky_ff == STATUS_NONE) begin
         if (ok != KIND_NONE) begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               st_nx = VERDICT_OVER;
            end else begin
               wr_en  = 1'b1;
               cnt_nx = count_ff + CW'(1);
               top_nx = ok;
            end
         end else if (ck != KIND_NONE) begin
            if (count_ff == '0) begin
               st_nx = VERDICT_UNBAL;
            end else begin
               cnt_nx = count_ff - CW'(1);
               top_nx = second;
               if (top_ff != ck) begin
                  st_nx = VERDICT_UNBAL;
               end
            end
         end
      end
   end

   always_comb begin
      result.is_final      = last_char;
      result.nesting_depth = DEPTH_W'(cnt_nx);
      if (!last_char) begin
         result.verdict = VERDICT_PEND;
      end else if (st_nx != STATUS_NONE) begin
         result.verdict = st_nx;
      end else if (cnt_nx == '0) begin
         result.verdict = VERDICT_BAL;
      end else begin
         result.verdict = VERDICT_UNBAL;
      end
   end

   assign count_in  = (item_valid && last_char) ? '0 : cnt_nx;
   assign sticky_in = (item_valid && last_char) ? STATUS_NONE : st_nx;
   assign top_in    = top_nx;
   assign rd_addr   = AW'(count_in - CW'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sticky_ff <= STATUS_NONE;
      end else begin
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
      top_ff <= top_in;
   end

endmodule

FILE: hdl/bbc_obuf.sv
// Two-entry result buffer: output register plus a skid register.
module bbc_obuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bbc_pkg::rsp_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bbc_pkg::rsp_item_type out_item
);

   import bbc_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         accept;

   assign in_ready = !skid_valid_ff;
   assign accept   = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_item_in  = in_item;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

FILE: hdl/bracket_balance_checker.sv
// Top level of the bracket balance checker: stack controller and result buffer.
//
//   Channel | Direction | Payload                                   | Item per
//   --------+-----------+-------------------------------------------+----------------
//   req_    | in        | tdata: char_in; tlast: last_char          | string byte
//   rsp_    | out       | tdata: verdict, nesting_depth; tlast: fin | string byte
//
// The block takes one item every clock cycle while req_tready is high and returns one result item per input item.
// Each item's result is computed combinationally in the stack controller and registered
// in the result buffer. The loop that sets the rate is the top-of-stack update: the top
// is held in a register and the entry below it is prefetched through the registered read
// port of the stack RAM, so pushes and pops can follow each other in consecutive cycles.
// Reset clears the stack count, the sticky status and the result buffer; the stack RAM
// itself is not cleared, since only entries below the count are ever read.
// A two-entry result buffer lets one more item in while a result waits, and req_tready
// drops only when both entries hold results that have not been taken.
module bracket_balance_checker #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // last_char

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] verdict, [9:2] nesting_depth, [15:10] zero
   output logic        rsp_tlast    // is_final
);

   import bbc_pkg::*;

   logic         item_valid;
   rsp_item_type core_result;
   rsp_item_type out_item;

   // An input item enters the stack controller in the cycle it is accepted.
   assign item_valid = req_tvalid && req_tready;

   bbc_core #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .char_in    (req_tdata[CHAR_W-1:0]),
      .last_char  (req_tlast),
      .result     (core_result)
   );

   bbc_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Output packing: verdict in the low bits, then the depth, then zero padding.
   assign rsp_tdata = {6'd0, out_item.nesting_depth, out_item.verdict};
   assign rsp_tlast = out_item.is_final;

endmodule

FILE: hdl/bbc_checker.sv
// Port-level checker for the bracket balance checker and its bind statement.
`include "assert_macros.svh"

module bbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   import bbc_pkg::*;

   // A result that is not taken stays on offer.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")

   // Only the final item of a string carries a verdict.
   `ASSERT_SAME(a_pending, clock, reset, rsp_tvalid && !rsp_tlast,
                rsp_tdata[1:0] == VERDICT_PEND, "verdict before final item")

   // A balanced string leaves nothing open on the stack.
   `ASSERT_SAME(a_bal_empty, clock, reset, rsp_tvalid && rsp_tdata[1:0] == VERDICT_BAL,
                rsp_tdata[9:2] == 8'd0 && rsp_tlast, "balanced with open brackets")

   // Reset empties the result buffer.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench of the bracket balance checker with a built-in stack predictor.
`timescale 1ns / 1ps

module tb_top;
   import bbc_pkg::*;

   localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
   // The long receiver hold-off, in cycles, used to fill the result buffer.
   localparam int HOLD_CYCLES  = 300;
   // Cycles without any handshake after which the run is declared hung.
   localparam int QUIET_LIMIT  = 4 * HOLD_CYCLES + 1000;
   localparam int RANDOM_ITEMS = 600;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_in
   logic        req_tlast  = 1'b0; // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [1:0] verdict, [9:2] nesting_depth, [15:10] zero
   logic        rsp_tlast;         // is_final

   // While set, neither side idles; the random test uses it for one long stretch.
   logic burst_mode   = 1'b0;
   // A test sets this flag to make the receiver hold off for the stretch set by HOLD_CYCLES.
   logic hold_request = 1'b0;

   int chars_sent     = 0;
   int mismatch_count = 0;

   // The predictor keeps its own copy of the bracket stack, the count and the sticky
   // status. Only entries below the count are ever read, so the array needs no reset.
   logic [KIND_W-1:0]    kind_stack [STACK_DEPTH];
   int                   open_count   = 0;
   logic [VERDICT_W-1:0] error_status = STATUS_NONE;

   // Results predicted for accepted items, oldest first.
   rsp_item_type pending_verdicts [$];

   bracket_balance_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Bracket decoding and predictor.
   // ---------------------------------------------------------------------------------

   function automatic logic [KIND_W-1:0] kind_of_opener(input logic [7:0] c);
      case (c)
         CHAR_OPEN_ROUND:  return KIND_ROUND;
         CHAR_OPEN_SQUARE: return KIND_SQUARE;
         CHAR_OPEN_CURLY:  return KIND_CURLY;
         default:          return KIND_NONE;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] kind_of_closer(input logic [7:0] c);
      case (c)
         CHAR_CLOSE_ROUND:  return KIND_ROUND;
         CHAR_CLOSE_SQUARE: return KIND_SQUARE;
         CHAR_CLOSE_CURLY:  return KIND_CURLY;
         default:           return KIND_NONE;
      endcase
   endfunction

   function automatic logic [7:0] opener_char(input logic [KIND_W-1:0] k);
      case (k)
         KIND_ROUND:  return CHAR_OPEN_ROUND;
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         default:     return CHAR_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(input logic [KIND_W-1:0] k);
      case (k)
         KIND_ROUND:  return CHAR_CLOSE_ROUND;
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         default:     return CHAR_CLOSE_CURLY;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] random_kind();
      logic [KIND_W-1:0] kinds [3];
      kinds = '{KIND_ROUND, KIND_SQUARE, KIND_CURLY};
      return kinds[$urandom_range(0, 2)];
   endfunction

   // Applies one accepted character to the predicted state and queues its result.
   // Once an error is recorded, the rest of the string is ignored, but the final
   // character still produces the verdict and clears the state.
   function automatic void track_brackets(input logic [7:0] c, input logic fin);
      logic [KIND_W-1:0] opens;
      logic [KIND_W-1:0] closes;
      rsp_item_type      r;
      opens  = kind_of_opener(c);
      closes = kind_of_closer(c);
      if (error_status == STATUS_NONE) begin
         if (opens != KIND_NONE) begin
            if (open_count >= STACK_DEPTH) begin
               error_status = VERDICT_OVER;
            end else begin
               kind_stack[open_count] = opens;
               open_count++;
            end
         end else if (closes != KIND_NONE) begin
            if (open_count == 0) begin
               // A close with nothing open leaves the stack untouched.
               error_status = VERDICT_UNBAL;
            end else begin
               // A mismatching close still pops the top.
               open_count--;
               if (kind_stack[open_count] != closes) error_status = VERDICT_UNBAL;
            end
         end
      end
      r.verdict = VERDICT_PEND;
      if (fin) begin
         if (error_status != STATUS_NONE) r.verdict = error_status;
         else if (open_count == 0)        r.verdict = VERDICT_BAL;
         else                             r.verdict = VERDICT_UNBAL;
      end
      r.is_final      = fin;
      r.nesting_depth = 8'(open_count);
      pending_verdicts.push_back(r);
      if (fin) begin
         open_count   = 0;
         error_status = STATUS_NONE;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender side.
   // ---------------------------------------------------------------------------------

   // Offers one character, idling at random beforehand unless in burst mode, and
   // waits for it to be taken. The prediction is made at acceptance.
   task automatic send_char(input logic [7:0] c, input logic fin);
      while (!burst_mode && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      track_brackets(c, fin);
      chars_sent++;
   endtask

   // Sends a whole string, flagging its last character as final.
   task automatic send_text(input logic [7:0] text [$]);
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Builds one random string. Most strings are properly nested bracket sequences
   // with random bytes mixed in, some are random mixes of brackets that usually go
   // wrong, and a rare one nests to a depth near or past the stack limit.
   task automatic send_random_string();
      logic [7:0]        text  [$];
      logic [KIND_W-1:0] opens [$];
      logic [KIND_W-1:0] k;
      int                style;
      int                len;
      int                pick;
      style = $urandom_range(0, 99);
      if (style < 1) begin
         len = $urandom_range(STACK_DEPTH - 28, STACK_DEPTH + 3);
         for (int i = 0; i < len; i++) begin
            k = random_kind();
            opens.push_back(k);
            text.push_back(opener_char(k));
         end
      end else if (style < 71) begin
         len = $urandom_range(0, 20);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               k = random_kind();
               opens.push_back(k);
               text.push_back(opener_char(k));
            end else if (pick < 75 && opens.size() > 0) begin
               text.push_back(closer_char(opens.pop_back()));
            end else begin
               text.push_back(8'($urandom_range(0, 255)));
            end
         end
      end else begin
         len = $urandom_range(1, 16);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      text.push_back(opener_char(random_kind()));
            else if (pick < 60) text.push_back(closer_char(random_kind()));
            else                text.push_back(8'($urandom_range(0, 255)));
         end
      end
      // Close whatever is still open so the well-formed strings end balanced.
      while (opens.size() > 0) text.push_back(closer_char(opens.pop_back()));
      if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
      send_text(text);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver side: random stalls, no stalls in burst mode, and one long hold-off
   // on request, counted here in its own cycles.
   // ---------------------------------------------------------------------------------
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (burst_mode) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 31);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result checking. Every accepted result is matched against the oldest prediction.
   // ---------------------------------------------------------------------------------

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual tdata %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            compare_field("verdict", want.verdict, rsp_tdata[1:0]);
            compare_field("nesting_depth", want.nesting_depth, rsp_tdata[9:2]);
            compare_field("is_final", want.is_final, rsp_tlast);
            compare_field("tdata padding", 0, rsp_tdata[15:10]);
         end
      end
   end

   // The watchdog ends a run in which nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // Short strings that hit each bracket kind, the byte extremes, a lone close,
   // an unclosed open, a kind mismatch and characters that follow an error.
   task automatic test_directed_strings();
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_string("()");
      send_string("[]");
      send_string("{}");
      send_string("([{}])");
      send_string(")");
      send_string("(");
      send_string("(]");
      send_string("](((");
      send_string("x(y)z");
   endtask

   // Fills the stack completely and empties it, then pushes past the top, once with
   // a close after the overflow and once with the overflowing push as final byte.
   task automatic test_stack_limits();
      for (int i = 0; i < STACK_DEPTH; i++) send_char(CHAR_OPEN_SQUARE, 1'b0);
      for (int i = 0; i < STACK_DEPTH; i++) send_char(CHAR_CLOSE_SQUARE, i == STACK_DEPTH - 1);
      for (int i = 0; i <= STACK_DEPTH; i++) send_char(CHAR_OPEN_CURLY, 1'b0);
      send_char(CHAR_CLOSE_CURLY, 1'b1);
      for (int i = 0; i < STACK_DEPTH; i++) send_char(CHAR_OPEN_ROUND, 1'b0);
      send_char(CHAR_OPEN_ROUND, 1'b1);
   endtask

   // The receiver stops for a long stretch while strings keep coming, so the result
   // buffer fills and the block has to stall its input.
   task automatic test_output_stall();
      int start;
      start        = chars_sent;
      hold_request = 1'b1;
      while (chars_sent < start + 40) send_random_string();
   endtask

   // Random strings up to the item budget, with one stretch in which neither
   // side idles.
   task automatic test_random_strings();
      int start;
      start = chars_sent;
      while (chars_sent < start + RANDOM_ITEMS) begin
         burst_mode = (chars_sent >= start + 200 && chars_sent < start + 400);
         send_random_string();
      end
      burst_mode = 1'b0;
   endtask

   initial begin : main
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_stack_limits();
      test_output_stall();
      test_random_strings();
      req_tvalid <= 1'b0;
      // Drain the remaining results, then idle for a short tail to catch any result that
      // is not expected.
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
